>>> rtl/core/bnc_pkg.sv
`default_nettype none

package bnc_pkg;

	// bracket kind as held on the stack
	typedef logic [1:0] kind_t;

	localparam kind_t KIND_ROUND  = 2'd0;
	localparam kind_t KIND_SQUARE = 2'd1;
	localparam kind_t KIND_CURLY  = 2'd2;
	localparam kind_t KIND_NONE   = 2'd3;

	typedef logic [2:0] err_t;

	localparam err_t ERR_NONE     = 3'd0;
	localparam err_t ERR_EMPTY    = 3'd1;
	localparam err_t ERR_MISMATCH = 3'd2;
	localparam err_t ERR_OPEN     = 3'd3;
	localparam err_t ERR_OVERFLOW = 3'd4;

	localparam logic [7:0] CHR_ROUND_OPEN   = 8'h28;
	localparam logic [7:0] CHR_ROUND_CLOSE  = 8'h29;
	localparam logic [7:0] CHR_SQUARE_OPEN  = 8'h5b;
	localparam logic [7:0] CHR_SQUARE_CLOSE = 8'h5d;
	localparam logic [7:0] CHR_CURLY_OPEN   = 8'h7b;
	localparam logic [7:0] CHR_CURLY_CLOSE  = 8'h7d;

	// operation on the stack for one cycle
	typedef struct packed {
		logic  push;
		logic  pop;
		logic  clear;
		kind_t kind;
	} stack_op_t;

	function automatic kind_t opener_kind(input logic [7:0] c);
		unique case (c)
			CHR_ROUND_OPEN:  opener_kind = KIND_ROUND;
			CHR_SQUARE_OPEN: opener_kind = KIND_SQUARE;
			CHR_CURLY_OPEN:  opener_kind = KIND_CURLY;
			default:         opener_kind = KIND_NONE;
		endcase
	endfunction

	function automatic kind_t closer_kind(input logic [7:0] c);
		unique case (c)
			CHR_ROUND_CLOSE:  closer_kind = KIND_ROUND;
			CHR_SQUARE_CLOSE: closer_kind = KIND_SQUARE;
			CHR_CURLY_CLOSE:  closer_kind = KIND_CURLY;
			default:          closer_kind = KIND_NONE;
		endcase
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bnc_stack.sv
`default_nettype none

module bnc_stack
	import bnc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire stack_op_t                        op,
	output logic [$clog2(STACK_DEPTH + 1) - 1:0] depth,
	output kind_t                                 top_kind
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	kind_t          mem [STACK_DEPTH];
	logic [DW-1:0]  depth_q;
	logic [DW-1:0]  depth_next;
	kind_t          top_q;
	kind_t          below_q;
	logic [DW-1:0]  raddr_full;
	logic [AW-1:0]  raddr;

	always_comb begin
		if (op.clear) begin
			depth_next = '0;
		end else if (op.push) begin
			depth_next = depth_q + DW'(1);
		end else if (op.pop) begin
			depth_next = depth_q - DW'(1);
		end else begin
			depth_next = depth_q;
		end
	end

	// keep the entry under the new top ready for a pop next cycle
	assign raddr_full = depth_next - DW'(2);
	assign raddr      = (depth_next < DW'(2)) ? '0 : raddr_full[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			depth_q <= depth_next;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q <= op.kind;
		end else if (op.pop) begin
			top_q <= below_q;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[depth_q[AW-1:0]] <= op.kind;
		end
		below_q <= mem[raddr];
	end

	assign depth    = depth_q;
	assign top_kind = top_q;

endmodule

`default_nettype wire

>>> rtl/core/bracket_nesting_checker_core.sv
`default_nettype none

// channel   signals                          transfer when
// input     in_valid, in_ready, char_code,   in_valid && in_ready
//           last
// result    out_valid, out_ready, balanced,  out_valid && out_ready
//           error_code
//
// one byte per cycle, back to back; the verdict appears in the output
// register the cycle after the final byte and a new string may follow at once
// the top of stack sits in a register and the entry below it is prefetched from the
// stack memory into a register, so pops and pushes run in consecutive cycles
// reset clears depth, error and output valid; stack memory is not cleared
// input stalls only while a verdict waits in the output register and
// out_ready is low

module bracket_nesting_checker_core
	import bnc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_code,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            balanced,
	output logic [2:0]      error_code
);

	localparam int DW = $clog2(STACK_DEPTH + 1);

	stack_op_t      op;
	logic [DW-1:0]  depth;
	kind_t          top_kind;
	kind_t          ok;
	kind_t          ck;
	logic           accept;
	err_t           err_q;
	err_t           err_new;
	err_t           verdict;
	logic           left_open;
	logic           out_valid_q;
	logic           balanced_q;
	err_t           error_code_q;

	bnc_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.depth    (depth),
		.top_kind (top_kind)
	);

	// output register frees the input side whenever it is empty or draining
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign ok = opener_kind(char_code);
	assign ck = closer_kind(char_code);

	// decide the stack action; once an error is held the rest is just consumed
	always_comb begin
		op.push  = 1'b0;
		op.pop   = 1'b0;
		op.clear = accept && last;
		op.kind  = ok;
		err_new  = err_q;
		if (accept && err_q == ERR_NONE) begin
			if (ok != KIND_NONE) begin
				if (depth == DW'(STACK_DEPTH)) begin
					err_new = ERR_OVERFLOW;
				end else begin
					op.push = 1'b1;
				end
			end else if (ck != KIND_NONE) begin
				if (depth == '0) begin
					err_new = ERR_EMPTY;
				end else if (top_kind != ck) begin
					err_new = ERR_MISMATCH;
				end else begin
					op.pop = 1'b1;
				end
			end
		end
	end

	// depth after this byte is nonzero
	assign left_open = op.push || (depth > DW'(1)) || (depth == DW'(1) && !op.pop);
	assign verdict   = (err_new == ERR_NONE && left_open) ? ERR_OPEN : err_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= ERR_NONE;
		end else if (accept) begin
			err_q <= last ? ERR_NONE : err_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// verdict payload, loaded only with a final byte
	always_ff @(posedge clk) begin
		if (accept && last) begin
			balanced_q   <= (verdict == ERR_NONE);
			error_code_q <= verdict;
		end
	end

	assign out_valid  = out_valid_q;
	assign balanced   = balanced_q;
	assign error_code = error_code_q;

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
	import bnc_pkg::*;

	localparam int NEST_LIMIT  = 64;
	localparam int ITEM_TARGET = 1750;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam int PLAN_ROWS   = 24;

	// one verdict as it leaves the result channel
	typedef struct packed {
		logic balanced;
		err_t code;
	} verdict_t;

	// one line of the directed plan: a byte sent reps times, last flag on the final copy
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic [7:0] reps;
		logic       typed;
		verdict_t   want;
	} plan_row_t;

	localparam verdict_t NO_VERDICT = '{1'b0, ERR_NONE};

	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// lone non-bracket byte on an empty stack
		'{8'h41,            1'b1, 8'd1,  1'b1, '{1'b1, ERR_NONE}},
		// every kind nested, with a high byte inside
		'{CHR_ROUND_OPEN,   1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{CHR_SQUARE_OPEN,  1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{CHR_CURLY_OPEN,   1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{8'hff,            1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{CHR_CURLY_CLOSE,  1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{CHR_SQUARE_CLOSE, 1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{CHR_ROUND_CLOSE,  1'b1, 8'd1,  1'b1, '{1'b1, ERR_NONE}},
		// closer with nothing open
		'{CHR_ROUND_CLOSE,  1'b1, 8'd1,  1'b1, '{1'b0, ERR_EMPTY}},
		// wrong kind, then a closer that would have matched is ignored
		'{CHR_SQUARE_OPEN,  1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{CHR_ROUND_CLOSE,  1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{CHR_SQUARE_CLOSE, 1'b1, 8'd1,  1'b1, '{1'b0, ERR_MISMATCH}},
		// opener left at the end, zero byte as final
		'{CHR_CURLY_OPEN,   1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{8'h00,            1'b1, 8'd1,  1'b1, '{1'b0, ERR_OPEN}},
		// an early error is kept over a later left-open
		'{CHR_CURLY_CLOSE,  1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{CHR_ROUND_OPEN,   1'b1, 8'd1,  1'b1, '{1'b0, ERR_EMPTY}},
		// stack filled exactly, then emptied
		'{CHR_CURLY_OPEN,   1'b0, 8'd64, 1'b0, NO_VERDICT},
		'{CHR_CURLY_CLOSE,  1'b0, 8'd63, 1'b0, NO_VERDICT},
		'{CHR_CURLY_CLOSE,  1'b1, 8'd1,  1'b1, '{1'b1, ERR_NONE}},
		// one opener past full, a later mismatch must not replace it
		'{CHR_SQUARE_OPEN,  1'b0, 8'd65, 1'b0, NO_VERDICT},
		'{CHR_ROUND_CLOSE,  1'b1, 8'd1,  1'b1, '{1'b0, ERR_OVERFLOW}},
		// single opener as the whole string
		'{CHR_ROUND_OPEN,   1'b1, 8'd1,  1'b1, '{1'b0, ERR_OPEN}},
		// top bit alone, then the other seven bits
		'{8'h80,            1'b0, 8'd1,  1'b0, NO_VERDICT},
		'{8'h7f,            1'b1, 8'd1,  1'b1, '{1'b1, ERR_NONE}}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_code;
	logic       last;
	logic       out_valid;
	logic       out_ready;
	logic       balanced;
	logic [2:0] error_code;

	// shadow of the checker state
	kind_t    nest_kinds [NEST_LIMIT];
	int       nest_depth;
	err_t     nest_first;

	// verdicts owed by the block, oldest first
	verdict_t verdict_q [$];

	logic     calm;
	int       mismatch_count;
	int       verdicts_checked;
	int       bytes_sent;
	int       strings_sent;
	int       quiet_cycles;
	int       code_hits [8];

	bracket_nesting_checker_core #(
		.STACK_DEPTH(NEST_LIMIT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.balanced  (balanced),
		.error_code(error_code)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// bracket byte of a given kind and direction
	function automatic logic [7:0] bracket_chr(input kind_t k, input logic closing);
		case (k)
			KIND_ROUND:  return closing ? CHR_ROUND_CLOSE : CHR_ROUND_OPEN;
			KIND_SQUARE: return closing ? CHR_SQUARE_CLOSE : CHR_SQUARE_OPEN;
			default:     return closing ? CHR_CURLY_CLOSE : CHR_CURLY_OPEN;
		endcase
	endfunction

	// random byte that is not a bracket
	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CHR_ROUND_OPEN || b == CHR_ROUND_CLOSE || b == CHR_SQUARE_OPEN ||
			b == CHR_SQUARE_CLOSE || b == CHR_CURLY_OPEN || b == CHR_CURLY_CLOSE);
		return b;
	endfunction

	// advance the shadow stack by one byte; on the final byte give the verdict and clear
	function automatic void nest_take(input logic [7:0] ch, input logic fin,
		output logic emits, output verdict_t v);
		kind_t opens;
		kind_t closes;
		err_t  code;
		opens  = KIND_NONE;
		closes = KIND_NONE;
		if (ch == CHR_ROUND_OPEN) opens = KIND_ROUND;
		else if (ch == CHR_SQUARE_OPEN) opens = KIND_SQUARE;
		else if (ch == CHR_CURLY_OPEN) opens = KIND_CURLY;
		else if (ch == CHR_ROUND_CLOSE) closes = KIND_ROUND;
		else if (ch == CHR_SQUARE_CLOSE) closes = KIND_SQUARE;
		else if (ch == CHR_CURLY_CLOSE) closes = KIND_CURLY;

		// once an error is latched the rest of the string has no effect
		if (nest_first == ERR_NONE) begin
			if (opens != KIND_NONE) begin
				if (nest_depth >= NEST_LIMIT) begin
					nest_first = ERR_OVERFLOW;
				end else begin
					nest_kinds[nest_depth] = opens;
					nest_depth++;
				end
			end else if (closes != KIND_NONE) begin
				if (nest_depth == 0) begin
					nest_first = ERR_EMPTY;
				end else if (nest_kinds[nest_depth - 1] != closes) begin
					nest_first = ERR_MISMATCH;
				end else begin
					nest_depth--;
				end
			end
		end

		code = nest_first;
		if (code == ERR_NONE && nest_depth != 0) code = ERR_OPEN;
		emits      = fin;
		v.balanced = (code == ERR_NONE);
		v.code     = code;
		if (fin) begin
			nest_depth = 0;
			nest_first = ERR_NONE;
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at %0t, verdict %0d: %s", $time, verdicts_checked, what);
	endtask

	// offer one byte, hold it until the transfer, then update the shadow state
	task automatic send_byte(input logic [7:0] ch, input logic fin, input logic typed,
		input verdict_t want);
		logic     emits;
		verdict_t v;
		while (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= ch;
		last      <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		nest_take(ch, fin, emits, v);
		// a typed-in verdict stands in for the predicted one
		if (emits) verdict_q.push_back(typed ? want : v);
		bytes_sent++;
		if (fin) strings_sent++;
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 8);
	end

	// every result transfer is matched against the oldest owed verdict
	always @(posedge clk) begin : verdict_check
		verdict_t exp_v;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result balanced=%b code=%0d",
					balanced, error_code));
			end else begin
				exp_v = verdict_q.pop_front();
				if (balanced !== exp_v.balanced)
					report_mismatch($sformatf("balanced %b, want %b", balanced,
						exp_v.balanced));
				if (error_code !== exp_v.code)
					report_mismatch($sformatf("error_code %0d, want %0d", error_code,
						exp_v.code));
			end
			if (!$isunknown(error_code)) code_hits[error_code]++;
			verdicts_checked++;
		end
	end

	// watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer, %0d verdicts owed",
				quiet_cycles, verdict_q.size());
			$display("bracket_nesting_checker_core verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned mode;
		int unsigned lim;
		int unsigned r;
		int          rand_strings;
		kind_t       k;
		kind_t       open_kinds [$];
		logic [7:0]  text_q [$];

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		char_code  <= 8'h00;
		last       <= 1'b0;
		calm       = 1'b0;
		nest_depth = 0;
		nest_first = ERR_NONE;
		rand_strings     = 0;
		bytes_sent       = 0;
		strings_sent     = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		for (int row = 0; row < PLAN_ROWS; row++) begin
			for (int j = 0; j < PLAN[row].reps; j++)
				send_byte(PLAN[row].ch, PLAN[row].fin && (j == PLAN[row].reps - 1),
					PLAN[row].typed, PLAN[row].want);
		end

		// random strings
		while (bytes_sent < ITEM_TARGET) begin
			// a run of strings with no idling on either side
			calm = (rand_strings >= 60 && rand_strings < 130);

			// sender holds off until every verdict is back
			if (rand_strings % 100 == 50) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (verdict_q.size() != 0) @(posedge clk);
			end

			text_q.delete();
			open_kinds.delete();
			mode = $urandom_range(0, 99);
			if (mode < 62) begin
				// well-formed nesting with filler, now and then one byte corrupted
				lim = $urandom_range(1, 8);
				repeat ($urandom_range(1, 14)) begin
					r = $urandom_range(0, 9);
					if (r < 4 && open_kinds.size() < lim) begin
						k = kind_t'($urandom_range(0, 2));
						open_kinds.push_back(k);
						text_q.push_back(bracket_chr(k, 1'b0));
					end else if (r < 8 && open_kinds.size() > 0) begin
						text_q.push_back(bracket_chr(open_kinds.pop_back(), 1'b1));
					end else begin
						text_q.push_back(filler_byte());
					end
				end
				while (open_kinds.size() > 0)
					text_q.push_back(bracket_chr(open_kinds.pop_back(), 1'b1));
				if ($urandom_range(0, 4) == 0)
					text_q[$urandom_range(0, text_q.size() - 1)] =
						bracket_chr(kind_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
			end else if (mode < 64) begin
				// deep nesting around the full mark, sometimes up to two past it
				repeat ($urandom_range(NEST_LIMIT - 4, NEST_LIMIT + 2)) begin
					k = kind_t'($urandom_range(0, 2));
					open_kinds.push_back(k);
					text_q.push_back(bracket_chr(k, 1'b0));
				end
				while (open_kinds.size() > 0)
					text_q.push_back(bracket_chr(open_kinds.pop_back(), 1'b1));
			end else if (mode < 86) begin
				// bracket soup, mostly broken
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 3) == 0)
						text_q.push_back(8'($urandom_range(0, 255)));
					else
						text_q.push_back(bracket_chr(kind_t'($urandom_range(0, 2)),
							1'($urandom_range(0, 1))));
				end
			end else begin
				// arbitrary bytes
				repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
			end

			for (int i = 0; i < text_q.size(); i++)
				send_byte(text_q[i], i == text_q.size() - 1, 1'b0, NO_VERDICT);
			rand_strings++;
		end

		// drain, then a short tail to catch stray results
		in_valid <= 1'b0;
		calm = 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d strings in %0d bytes, %0d verdicts compared",
			strings_sent, bytes_sent, verdicts_checked);
		$display("verdicts by code: ok %0d, empty %0d, mismatch %0d, open %0d, overflow %0d",
			code_hits[ERR_NONE], code_hits[ERR_EMPTY], code_hits[ERR_MISMATCH],
			code_hits[ERR_OPEN], code_hits[ERR_OVERFLOW]);
		if (mismatch_count == 0)
			$display("bracket_nesting_checker_core verification clean");
		else
			$display("bracket_nesting_checker_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire
